// ----- hw/rtl/compass_heading_from_magnetometer_assert.svh -----
// Assertion macros for the compass heading RTL.
`ifndef COMPASS_HEADING_FROM_MAGNETOMETER_ASSERT_SVH
`define COMPASS_HEADING_FROM_MAGNETOMETER_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CHB_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("compass heading assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define CHB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("compass heading assertion failed");

`endif

// ----- hw/rtl/chb_pkg.sv -----
// Package with the widths, constants, types and arctangent table of the compass heading block.
`timescale 1ns / 1ps

package chb_pkg;

   localparam int AXIS_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int GAIN_W    = 16;
   localparam int FRAC_W    = 4;
   localparam int DIFF_W    = AXIS_W + FRAC_W + 1;
   localparam int XPROD_W   = DIFF_W + GAIN_W + 1;
   localparam int ZPROD_W   = AXIS_W + GAIN_W + 1;
   localparam int XY_SHIFT  = 19;
   localparam int Z_SHIFT   = 15;
   localparam int SAT_MAX   = 32767;
   localparam int SAT_MIN   = -32768;

   localparam int PRE_SHIFT = 8;
   localparam int VEC_W     = 27;
   localparam int ANGLE_W   = 26;
   localparam int HEAD_W    = 16;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_RUN   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   localparam logic signed [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180 * 65536);
   localparam logic signed [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360 * 65536);
   localparam int ROUND_SHIFT  = 9;
   localparam int ROUND_HALF   = 256;
   localparam int HEADING_WRAP = 46080;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(30147);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_GAIN = 2'd2;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x_scaled;
      logic signed [AXIS_W-1:0] y_scaled;
      logic signed [AXIS_W-1:0] z_scaled;
      logic signed [AXIS_W-1:0] x_packed;
      logic signed [AXIS_W-1:0] y_packed;
      logic signed [AXIS_W-1:0] z_packed;
   } axes_type;

   typedef struct packed {
      logic signed [VEC_W-1:0]   x;
      logic signed [VEC_W-1:0]   y;
      logic signed [ANGLE_W-1:0] z;
      logic                      zero;
      axes_type                  axes;
   } vec_type;

   // Arctangent of 2^-idx in units of 1/65536 degree, rounded to nearest.
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input int idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         0:       val = ANGLE_W'(2949120);
         1:       val = ANGLE_W'(1740967);
         2:       val = ANGLE_W'(919879);
         3:       val = ANGLE_W'(466945);
         4:       val = ANGLE_W'(234379);
         5:       val = ANGLE_W'(117304);
         6:       val = ANGLE_W'(58666);
         7:       val = ANGLE_W'(29335);
         8:       val = ANGLE_W'(14668);
         9:       val = ANGLE_W'(7334);
         10:      val = ANGLE_W'(3667);
         11:      val = ANGLE_W'(1833);
         12:      val = ANGLE_W'(917);
         13:      val = ANGLE_W'(458);
         14:      val = ANGLE_W'(229);
         15:      val = ANGLE_W'(115);
         16:      val = ANGLE_W'(57);
         17:      val = ANGLE_W'(29);
         18:      val = ANGLE_W'(14);
         19:      val = ANGLE_W'(7);
         20:      val = ANGLE_W'(4);
         21:      val = ANGLE_W'(2);
         22:      val = ANGLE_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- hw/rtl/chb_cordic.sv -----
// Pipelined vectoring CORDIC, one registered iteration per stage.
`timescale 1ns / 1ps

module chb_cordic (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  chb_pkg::vec_type in_vec,
   output logic             out_valid,
   input  logic             out_ready,
   output chb_pkg::vec_type out_vec
);
   import chb_pkg::*;

   logic    valid_ff [CORDIC_RUN];
   vec_type vec_ff   [CORDIC_RUN];
   vec_type vec_in   [CORDIC_RUN];
   logic    adv      [CORDIC_RUN];

   for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_step
      vec_type prev;
      logic    prev_valid;
      logic    next_adv;

      if (i == 0) begin : g_first
         assign prev       = in_vec;
         assign prev_valid = in_valid;
      end else begin : g_rest
         assign prev       = vec_ff[i-1];
         assign prev_valid = valid_ff[i-1];
      end

      if (i == CORDIC_RUN - 1) begin : g_last
         assign next_adv = out_ready;
      end else begin : g_mid
         assign next_adv = adv[i+1];
      end

      assign adv[i] = !valid_ff[i] || next_adv;

      always_comb begin
         vec_in[i] = prev;
         if (prev.y > 0) begin
            vec_in[i].x = prev.x + (prev.y >>> i);
            vec_in[i].y = prev.y - (prev.x >>> i);
            vec_in[i].z = prev.z + atan_entry(i);
         end else begin
            vec_in[i].x = prev.x - (prev.y >>> i);
            vec_in[i].y = prev.y + (prev.x >>> i);
            vec_in[i].z = prev.z - atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            vec_ff[i] <= vec_in[i];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[CORDIC_RUN-1];
   assign out_vec   = vec_ff[CORDIC_RUN-1];

endmodule

// ----- hw/rtl/compass_heading_from_magnetometer.sv -----
// Top level of the compass heading block: axis packing, scaling, CORDIC heading and output.
`timescale 1ns / 1ps

// The block takes one word of six magnetometer bytes per cycle while req_stall is low and
// returns one word per input through four scaling stages, one stage per CORDIC iteration
// with sixteen iterations, then a wrap stage and the output register. Every stage holds its
// word under stall and a bubble anywhere in the pipeline lets a new word in while a result
// waits at the output. Configuration registers are written through the csr port, which is
// always ready; write them only while no word is in flight.
`include "compass_heading_from_magnetometer_assert.svh"

module compass_heading_from_magnetometer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [chb_pkg::BYTE_W-1:0]            req_x_high,
   input  logic [chb_pkg::BYTE_W-1:0]            req_x_low,
   input  logic [chb_pkg::BYTE_W-1:0]            req_z_high,
   input  logic [chb_pkg::BYTE_W-1:0]            req_z_low,
   input  logic [chb_pkg::BYTE_W-1:0]            req_y_high,
   input  logic [chb_pkg::BYTE_W-1:0]            req_y_low,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [chb_pkg::HEAD_W-1:0]            rsp_heading,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_x_scaled,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_y_scaled,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_z_scaled,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_x_packed,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_y_packed,
   output logic signed [chb_pkg::AXIS_W-1:0]     rsp_z_packed,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [chb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [chb_pkg::AXIS_W-1:0]            csr_data
);
   import chb_pkg::*;

   localparam logic signed [XPROD_W-1:0] XY_BIAS = XPROD_W'((1 << XY_SHIFT) - 1);
   localparam logic signed [ZPROD_W-1:0] Z_BIAS  = ZPROD_W'((1 << Z_SHIFT) - 1);

   logic signed [AXIS_W-1:0] x_offset_ff;
   logic signed [AXIS_W-1:0] y_offset_ff;
   logic [GAIN_W-1:0]        axis_gain_ff;

   logic adv1, adv2, adv3, adv4, adv5, adv_out;

   logic                      s1_valid_ff;
   logic signed [AXIS_W-1:0]  s1_xp_ff, s1_yp_ff, s1_zp_ff;
   logic signed [AXIS_W-1:0]  s1_xp_in, s1_yp_in, s1_zp_in;
   logic signed [DIFF_W-1:0]  s1_xd_ff, s1_yd_ff;
   logic signed [DIFF_W-1:0]  s1_xd_in, s1_yd_in;

   logic                      s2_valid_ff;
   logic signed [AXIS_W-1:0]  s2_xp_ff, s2_yp_ff, s2_zp_ff;
   logic signed [XPROD_W-1:0] s2_xm_ff, s2_ym_ff;
   logic signed [XPROD_W-1:0] s2_xm_in, s2_ym_in;
   logic signed [ZPROD_W-1:0] s2_zm_ff;
   logic signed [ZPROD_W-1:0] s2_zm_in;

   logic                      s3_valid_ff;
   axes_type                  s3_ff;
   axes_type                  s3_in;
   logic signed [XPROD_W-1:0] xq, yq;
   logic signed [ZPROD_W-1:0] zq;

   logic                      s4_valid_ff;
   vec_type                   s4_ff;
   vec_type                   s4_in;
   logic signed [VEC_W-1:0]   x0, y0;

   logic                      cordic_ready;
   logic                      cordic_valid;
   vec_type                   cordic_vec;

   logic                      s5_valid_ff;
   logic signed [ANGLE_W-1:0] s5_z_ff;
   logic signed [ANGLE_W-1:0] s5_z_in;
   logic                      s5_zero_ff;
   axes_type                  s5_axes_ff;

   logic                      rsp_valid_ff;
   logic [HEAD_W-1:0]         rsp_heading_ff;
   logic [HEAD_W-1:0]         rsp_heading_in;
   axes_type                  rsp_axes_ff;
   logic signed [ANGLE_W-1:0] zr;

   logic                      rsp_axes_zero;
   logic                      gain_write;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff  <= '0;
         y_offset_ff  <= '0;
         axis_gain_ff <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_X_OFFSET) begin
            x_offset_ff <= $signed(csr_data);
         end
         if (csr_index == CSR_Y_OFFSET) begin
            y_offset_ff <= $signed(csr_data);
         end
         if (csr_index == CSR_AXIS_GAIN) begin
            axis_gain_ff <= csr_data;
         end
      end
   end

   // Stage advance chain, from the output backwards.
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv5      = !s5_valid_ff || adv_out;
   assign adv4      = !s4_valid_ff || cordic_ready;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   // Stage 1: pack the bytes and remove the hard-iron offsets.
   always_comb begin
      s1_xp_in = $signed({req_x_high, req_x_low});
      s1_yp_in = $signed({req_y_high, req_y_low});
      s1_zp_in = $signed({req_z_high, req_z_low});
      s1_xd_in = (DIFF_W'(s1_xp_in) <<< FRAC_W) - DIFF_W'(x_offset_ff);
      s1_yd_in = (DIFF_W'(s1_yp_in) <<< FRAC_W) - DIFF_W'(y_offset_ff);
   end

   // Stage 2: gain products.
   always_comb begin
      s2_xm_in = XPROD_W'(s1_xd_ff) * XPROD_W'($signed({1'b0, axis_gain_ff}));
      s2_ym_in = XPROD_W'(s1_yd_ff) * XPROD_W'($signed({1'b0, axis_gain_ff}));
      s2_zm_in = ZPROD_W'(s1_zp_ff) * ZPROD_W'($signed({1'b0, axis_gain_ff}));
   end

   // Stage 3: truncate toward zero and saturate.
   always_comb begin
      xq = (s2_xm_ff + (s2_xm_ff[XPROD_W-1] ? XY_BIAS : XPROD_W'(0))) >>> XY_SHIFT;
      yq = (s2_ym_ff + (s2_ym_ff[XPROD_W-1] ? XY_BIAS : XPROD_W'(0))) >>> XY_SHIFT;
      zq = (s2_zm_ff + (s2_zm_ff[ZPROD_W-1] ? Z_BIAS : ZPROD_W'(0))) >>> Z_SHIFT;
      s3_in.x_packed = s2_xp_ff;
      s3_in.y_packed = s2_yp_ff;
      s3_in.z_packed = s2_zp_ff;
      priority if (xq > SAT_MAX) s3_in.x_scaled = AXIS_W'(SAT_MAX);
      else if (xq < SAT_MIN)     s3_in.x_scaled = AXIS_W'(SAT_MIN);
      else                       s3_in.x_scaled = AXIS_W'(xq);
      priority if (yq > SAT_MAX) s3_in.y_scaled = AXIS_W'(SAT_MAX);
      else if (yq < SAT_MIN)     s3_in.y_scaled = AXIS_W'(SAT_MIN);
      else                       s3_in.y_scaled = AXIS_W'(yq);
      priority if (zq > SAT_MAX) s3_in.z_scaled = AXIS_W'(SAT_MAX);
      else if (zq < SAT_MIN)     s3_in.z_scaled = AXIS_W'(SAT_MIN);
      else                       s3_in.z_scaled = AXIS_W'(zq);
   end

   // Stage 4: scale up for the CORDIC and rotate by half a turn when x is negative.
   always_comb begin
      x0 = VEC_W'(s3_ff.x_scaled) <<< PRE_SHIFT;
      y0 = VEC_W'(s3_ff.y_scaled) <<< PRE_SHIFT;
      s4_in.axes = s3_ff;
      s4_in.zero = (s3_ff.x_scaled == '0) && (s3_ff.y_scaled == '0);
      if (s3_ff.x_scaled < 0) begin
         s4_in.x = -x0;
         s4_in.y = -y0;
         s4_in.z = DEG_180;
      end else begin
         s4_in.x = x0;
         s4_in.y = y0;
         s4_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_xp_ff <= s1_xp_in;
         s1_yp_ff <= s1_yp_in;
         s1_zp_ff <= s1_zp_in;
         s1_xd_ff <= s1_xd_in;
         s1_yd_ff <= s1_yd_in;
      end
      if (adv2) begin
         s2_xp_ff <= s1_xp_ff;
         s2_yp_ff <= s1_yp_ff;
         s2_zp_ff <= s1_zp_ff;
         s2_xm_ff <= s2_xm_in;
         s2_ym_ff <= s2_ym_in;
         s2_zm_ff <= s2_zm_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
      if (adv4) begin
         s4_ff <= s4_in;
      end
   end

   chb_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (cordic_ready),
      .in_vec    (s4_ff),
      .out_valid (cordic_valid),
      .out_ready (adv5),
      .out_vec   (cordic_vec)
   );

   // Stage 5: wrap the angle into one full turn.
   always_comb begin
      priority if (cordic_vec.z < 0) s5_z_in = cordic_vec.z + DEG_360;
      else if (cordic_vec.z >= DEG_360) s5_z_in = cordic_vec.z - DEG_360;
      else s5_z_in = cordic_vec.z;
   end

   // Output stage: round to 1/128 degree, wrap a full turn to zero and give zero for a zero vector.
   always_comb begin
      zr = (s5_z_ff + ANGLE_W'(ROUND_HALF)) >>> ROUND_SHIFT;
      priority if (s5_zero_ff) rsp_heading_in = '0;
      else if (zr >= ANGLE_W'(HEADING_WRAP)) rsp_heading_in = HEAD_W'(zr - ANGLE_W'(HEADING_WRAP));
      else rsp_heading_in = HEAD_W'(zr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv5)    s5_valid_ff  <= cordic_valid;
         if (adv_out) rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_z_ff    <= s5_z_in;
         s5_zero_ff <= cordic_vec.zero;
         s5_axes_ff <= cordic_vec.axes;
      end
      if (adv_out) begin
         rsp_heading_ff <= rsp_heading_in;
         rsp_axes_ff    <= s5_axes_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_heading  = rsp_heading_ff;
   assign rsp_x_scaled = rsp_axes_ff.x_scaled;
   assign rsp_y_scaled = rsp_axes_ff.y_scaled;
   assign rsp_z_scaled = rsp_axes_ff.z_scaled;
   assign rsp_x_packed = rsp_axes_ff.x_packed;
   assign rsp_y_packed = rsp_axes_ff.y_packed;
   assign rsp_z_packed = rsp_axes_ff.z_packed;

   assign rsp_axes_zero = (rsp_axes_ff.x_scaled == '0) && (rsp_axes_ff.y_scaled == '0);
   assign gain_write    = csr_valid && csr_ready && (csr_index == CSR_AXIS_GAIN);

   `CHB_ASSERT_IMPLIES(a_heading_range, rsp_valid_ff, rsp_heading_ff < HEAD_W'(HEADING_WRAP))
   `CHB_ASSERT_IMPLIES(a_zero_heading, rsp_valid_ff && rsp_axes_zero, rsp_heading_ff == '0)
   `CHB_ASSERT_IMPLIES(a_empty_accepts, !rsp_valid_ff, !req_stall)
   `CHB_ASSERT_NEXT(a_accept_lands, req_valid && !req_stall, s1_valid_ff)
   `CHB_ASSERT_NEXT(a_gain_write, gain_write, axis_gain_ff == $past(csr_data))

endmodule

// ----- tb/tb_compass_heading_from_magnetometer.sv -----
// Self-checking testbench for the compass heading block, with a scoreboard class.
`timescale 1ns / 1ps

module tb_compass_heading_from_magnetometer;

   import chb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int ARCTAN_LEN = 24;
   localparam longint ARCTAN_TABLE [ARCTAN_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };
   localparam longint HALF_TURN = 180 * 65536;
   localparam longint FULL_TURN = 360 * 65536;
   localparam longint HEADING_STEPS = 46080;
   localparam int RANDOM_PER_SETTING = 72;
   localparam int SETTING_COUNT = 6;

   typedef struct packed {
      logic [HEAD_W-1:0]        heading;
      logic signed [AXIS_W-1:0] x_scaled;
      logic signed [AXIS_W-1:0] y_scaled;
      logic signed [AXIS_W-1:0] z_scaled;
      logic signed [AXIS_W-1:0] x_packed;
      logic signed [AXIS_W-1:0] y_packed;
      logic signed [AXIS_W-1:0] z_packed;
   } heading_word_type;

   class heading_scoreboard;
      longint x_offset;
      longint y_offset;
      longint axis_gain;
      heading_word_type expected_words[$];
      int failures;
      int compared;

      function new();
         x_offset  = 0;
         y_offset  = 0;
         axis_gain = 30147;
         failures  = 0;
         compared  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [AXIS_W-1:0] data);
         case (index)
            CSR_X_OFFSET: begin
               x_offset = longint'($signed(data));
            end
            CSR_Y_OFFSET: begin
               y_offset = longint'($signed(data));
            end
            CSR_AXIS_GAIN: begin
               axis_gain = longint'(data);
            end
            default: begin
            end
         endcase
      endfunction

      function longint clamp_axis(longint v);
         if (v > SAT_MAX) return SAT_MAX;
         if (v < SAT_MIN) return SAT_MIN;
         return v;
      endfunction

      function longint cordic_heading(longint xs, longint ys);
         longint vx;
         longint vy;
         longint ang;
         longint t;
         int steps;
         steps = (CORDIC_STEPS > ARCTAN_LEN) ? ARCTAN_LEN : CORDIC_STEPS;
         if (xs == 0 && ys == 0) return 0;
         vx  = xs * 256;
         vy  = ys * 256;
         ang = 0;
         if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = HALF_TURN;
         end
         for (int i = 0; i < steps; i++) begin
            t = vx;
            if (vy > 0) begin
               vx  = vx + (vy >>> i);
               vy  = vy - (t >>> i);
               ang = ang + ARCTAN_TABLE[i];
            end else begin
               vx  = vx - (vy >>> i);
               vy  = vy + (t >>> i);
               ang = ang - ARCTAN_TABLE[i];
            end
         end
         if (ang < 0) ang += FULL_TURN;
         if (ang >= FULL_TURN) ang -= FULL_TURN;
         ang = (ang + 256) >>> 9;
         if (ang >= HEADING_STEPS) ang -= HEADING_STEPS;
         return ang;
      endfunction

      function void note_sample(logic [7:0] xh, logic [7:0] xl, logic [7:0] zh,
                                logic [7:0] zl, logic [7:0] yh, logic [7:0] yl);
         heading_word_type w;
         longint xp;
         longint yp;
         longint zp;
         longint xs;
         longint ys;
         longint zs;
         xp = longint'($signed({xh, xl}));
         yp = longint'($signed({yh, yl}));
         zp = longint'($signed({zh, zl}));
         xs = clamp_axis(((xp * 16 - x_offset) * axis_gain) / 524288);
         ys = clamp_axis(((yp * 16 - y_offset) * axis_gain) / 524288);
         zs = clamp_axis((zp * axis_gain) / 32768);
         w.heading  = HEAD_W'(cordic_heading(xs, ys));
         w.x_scaled = AXIS_W'(xs);
         w.y_scaled = AXIS_W'(ys);
         w.z_scaled = AXIS_W'(zs);
         w.x_packed = AXIS_W'(xp);
         w.y_packed = AXIS_W'(yp);
         w.z_packed = AXIS_W'(zp);
         expected_words.push_back(w);
      endfunction

      function void check_result(heading_word_type got);
         heading_word_type want;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result word with nothing expected: heading %0d", $realtime,
                        got.heading);
            return;
         end
         want = expected_words.pop_front();
         compared++;
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: mismatch, expected heading %0d scaled %0d %0d %0d raw %0d %0d %0d",
                        $realtime, want.heading, want.x_scaled, want.y_scaled, want.z_scaled,
                        want.x_packed, want.y_packed, want.z_packed);
               $display("%0t:           actual heading %0d scaled %0d %0d %0d raw %0d %0d %0d",
                        $realtime, got.heading, got.x_scaled, got.y_scaled, got.z_scaled,
                        got.x_packed, got.y_packed, got.z_packed);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [BYTE_W-1:0] req_x_high = '0;
   logic [BYTE_W-1:0] req_x_low = '0;
   logic [BYTE_W-1:0] req_z_high = '0;
   logic [BYTE_W-1:0] req_z_low = '0;
   logic [BYTE_W-1:0] req_y_high = '0;
   logic [BYTE_W-1:0] req_y_low = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [HEAD_W-1:0] rsp_heading;
   logic signed [AXIS_W-1:0] rsp_x_scaled;
   logic signed [AXIS_W-1:0] rsp_y_scaled;
   logic signed [AXIS_W-1:0] rsp_z_scaled;
   logic signed [AXIS_W-1:0] rsp_x_packed;
   logic signed [AXIS_W-1:0] rsp_y_packed;
   logic signed [AXIS_W-1:0] rsp_z_packed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_X_OFFSET;
   logic [AXIS_W-1:0] csr_data = '0;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int samples_sent = 0;
   heading_scoreboard board = new();

   compass_heading_from_magnetometer u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_high   (req_x_high),
      .req_x_low    (req_x_low),
      .req_z_high   (req_z_high),
      .req_z_low    (req_z_low),
      .req_y_high   (req_y_high),
      .req_y_low    (req_y_low),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_heading  (rsp_heading),
      .rsp_x_scaled (rsp_x_scaled),
      .rsp_y_scaled (rsp_y_scaled),
      .rsp_z_scaled (rsp_z_scaled),
      .rsp_x_packed (rsp_x_packed),
      .rsp_y_packed (rsp_y_packed),
      .rsp_z_packed (rsp_z_packed),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      heading_word_type got;
      if (!reset && req_valid && !req_stall)
         board.note_sample(req_x_high, req_x_low, req_z_high, req_z_low, req_y_high, req_y_low);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.heading  = rsp_heading;
         got.x_scaled = rsp_x_scaled;
         got.y_scaled = rsp_y_scaled;
         got.z_scaled = rsp_z_scaled;
         got.x_packed = rsp_x_packed;
         got.y_packed = rsp_y_packed;
         got.z_packed = rsp_z_packed;
         board.check_result(got);
      end
   end

   task automatic send_axes(shortint x, shortint z, shortint y);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_x_high <= x[15:8];
      req_x_low  <= x[7:0];
      req_z_high <= z[15:8];
      req_z_low  <= z[7:0];
      req_y_high <= y[15:8];
      req_y_low  <= y[7:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [AXIS_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_register(index, data);
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [AXIS_W-1:0] xo, logic [AXIS_W-1:0] yo,
                                logic [AXIS_W-1:0] gain);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_words.size() != 0) @(posedge clock);
      write_register(CSR_X_OFFSET, xo);
      write_register(CSR_Y_OFFSET, yo);
      write_register(CSR_AXIS_GAIN, gain);
   endtask

   function automatic shortint pick_axis(longint offset);
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         5, 6: return shortint'(offset / 16 + $urandom_range(0, 8) - 4);
         7: begin
            case ($urandom_range(0, 4))
               0: return -32768;
               1: return 32767;
               2: return -1;
               3: return 1;
               default: return 0;
            endcase
         end
         8, 9: return shortint'(int'($urandom_range(0, 1023)) - 512);
         default: return shortint'($urandom);
      endcase
   endfunction

   task automatic send_random_sample();
      shortint x;
      shortint y;
      shortint z;
      x = pick_axis(board.x_offset);
      y = pick_axis(board.y_offset);
      z = pick_axis(0);
      case ($urandom_range(0, 19))
         0: y = x;
         1: y = -x;
         default: begin
         end
      endcase
      send_axes(x, z, y);
   endtask

   initial begin
      logic [AXIS_W-1:0] set_x [SETTING_COUNT];
      logic [AXIS_W-1:0] set_y [SETTING_COUNT];
      logic [AXIS_W-1:0] set_gain [SETTING_COUNT];

      set_x[0] = 16'h0000;  set_y[0] = 16'h0000;  set_gain[0] = 16'd30147;
      set_x[1] = AXIS_W'($urandom);
      set_y[1] = AXIS_W'($urandom);
      set_gain[1] = AXIS_W'($urandom);
      set_x[2] = 16'h8000;  set_y[2] = 16'h7FFF;  set_gain[2] = 16'hFFFF;
      set_x[3] = AXIS_W'($urandom);
      set_y[3] = AXIS_W'($urandom);
      set_gain[3] = 16'h8000;
      set_x[4] = 16'h7FFF;  set_y[4] = 16'h8000;  set_gain[4] = 16'd1;
      set_x[5] = 16'($urandom_range(0, 2047)) - 16'd1024;
      set_y[5] = 16'($urandom_range(0, 2047)) - 16'd1024;
      set_gain[5] = 16'd30147;

      req_idle_pct = 34;
      rsp_idle_pct = 52;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Compass points, the diagonals, the zero vector and the extremes at reset gain.
      send_axes(0, 0, 0);
      send_axes(100, 0, 0);
      send_axes(-100, 0, 0);
      send_axes(0, 0, 100);
      send_axes(0, 0, -100);
      send_axes(100, 0, 100);
      send_axes(-100, 0, 100);
      send_axes(-100, 0, -100);
      send_axes(100, 0, -100);
      send_axes(32767, 32767, 32767);
      send_axes(-32768, -32768, -32768);
      send_axes(-1, -1, -1);
      send_axes(1000, 5, -1);
      send_axes(21845, -21846, 21845);
      send_axes(-21846, 21845, -21846);

      // Saturation of all three products at full gain and extreme offsets.
      apply_setting(16'h7FFF, 16'h8000, 16'hFFFF);
      send_axes(32767, 32767, 32767);
      send_axes(-32768, -32768, -32768);
      send_axes(0, 0, 0);
      send_axes(2048, 0, -2048);

      // Zero gain leaves all three scaled axes at zero.
      apply_setting(16'h8000, 16'h7FFF, 16'h0000);
      send_axes(1234, -5, 4321);

      for (int s = 0; s < SETTING_COUNT; s++) begin
         if (s == 2) begin
            req_idle_pct = 52;
            rsp_idle_pct = 34;
         end else if (s == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         apply_setting(set_x[s], set_y[s], set_gain[s]);
         if (s == SETTING_COUNT - 1)
            write_register(CSR_SPARE, AXIS_W'($urandom));
         for (int n = 0; n < RANDOM_PER_SETTING; n++)
            send_random_sample();
      end
      req_valid <= 1'b0;

      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d magnetometer words over %0d register settings, %0d results compared.",
               samples_sent, SETTING_COUNT + 3, board.compared);
      $display("Failures found: %0d.", board.failures);
      if (board.failures == 0 && board.expected_words.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d words outstanding.", board.expected_words.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
